// ===== rtl/core/vdgs_pkg.sv =====
package vdgs_pkg;

  // Delay ring geometry
  localparam int DELAY_DEPTH = 4096;
  localparam int ADDR_W      = $clog2(DELAY_DEPTH);
  localparam int FILL_W      = $clog2(DELAY_DEPTH + 1);

  // Field widths
  localparam int SAMPLE_W = 24;
  localparam int GAIN_W   = 16;
  localparam int COEF_W   = 16;
  localparam int OFF_W    = 12;
  localparam int SG_W     = 32;

  // Digit-serial multiply geometry
  localparam int DIG_W     = 8;
  localparam int SM_DIGITS = COEF_W / DIG_W;
  localparam int WG_DIGITS = SG_W / DIG_W;
  localparam int CNT_W     = $clog2(WG_DIGITS);

  // Gain constants
  localparam logic [SG_W-1:0]   GAIN_FLOOR = SG_W'(214748);
  localparam logic [GAIN_W-1:0] UNITY_Q15  = GAIN_W'(32768);

  // Configuration register map
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;
  localparam logic [CFG_IDX_W-1:0] CFG_DELAY_OFFSET = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_ATTACK_COEF  = CFG_IDX_W'(1);
  localparam logic [CFG_IDX_W-1:0] CFG_RELEASE_COEF = CFG_IDX_W'(2);
  localparam logic [COEF_W-1:0] ATTACK_RST  = COEF_W'(57);
  localparam logic [COEF_W-1:0] RELEASE_RST = COEF_W'(273);

  // Block modes
  localparam logic [1:0] MODE_IDLE    = 2'd0;
  localparam logic [1:0] MODE_SILENT  = 2'd1;
  localparam logic [1:0] MODE_AUDIBLE = 2'd2;

  typedef struct packed {
    logic wr;
    logic restart;
    logic rd;
  } ring_ctrl_t;

  typedef struct packed {
    logic clr;
    logic load;
    logic mac;
    logic upd;
  } sm_ctrl_t;

  typedef struct packed {
    logic load;
    logic mac;
  } wg_ctrl_t;

endpackage

// ===== rtl/core/voice_delay_gain_smoother.sv =====
// Audible beat: decide, read the ring, smooth both gains, weigh the sample, then finish.
// Idle or silent beat: decide, then finish; a new beat is taken only back in idle.
// An audible beat runs through the 8-bit digit-serial multipliers: two digits of the
// smoothing coefficient, then four digits of the smoothed gain.
// A new beat is taken while a finished result still waits in the output register.
// Synchronous active-low reset clears control, gains and the ring write pointer and fill count; no clearing pass.
module voice_delay_gain_smoother import vdgs_pkg::*; (
  input  logic                       clk,
  input  logic                       rst_n,
  // input beats
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic signed [SAMPLE_W-1:0] in_voice_sample,
  input  logic [GAIN_W-1:0]          in_target_gain_left,
  input  logic [GAIN_W-1:0]          in_target_gain_right,
  input  logic                       in_voice_enabled,
  input  logic                       in_block_start,
  // result beats
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic signed [SAMPLE_W-1:0] out_left_out,
  output logic signed [SAMPLE_W-1:0] out_right_out,
  // configuration writes
  input  logic                       cfg_valid,
  output logic                       cfg_ready,
  input  logic [CFG_IDX_W-1:0]       cfg_index,
  input  logic [CFG_DATA_W-1:0]      cfg_data
);

  localparam int ST_W = 3;
  localparam logic [ST_W-1:0] ST_IDLE = 3'd0;
  localparam logic [ST_W-1:0] ST_DEC  = 3'd1;
  localparam logic [ST_W-1:0] ST_RD   = 3'd2;
  localparam logic [ST_W-1:0] ST_SM   = 3'd3;
  localparam logic [ST_W-1:0] ST_UPD  = 3'd4;
  localparam logic [ST_W-1:0] ST_WG   = 3'd5;
  localparam logic [ST_W-1:0] ST_FIN  = 3'd6;

  logic [ST_W-1:0]  state_r, state_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [1:0]       mode_r, mode_nxt;
  logic             running_r, running_nxt;

  logic [OFF_W-1:0]  offset_r;
  logic [COEF_W-1:0] attack_r;
  logic [COEF_W-1:0] release_r;

  logic [SAMPLE_W-1:0] sample_r;
  logic [GAIN_W-1:0]   tl_r;
  logic [GAIN_W-1:0]   tr_r;
  logic                en_r;
  logic                bs_r;

  logic                       out_valid_r;
  logic signed [SAMPLE_W-1:0] out_left_r;
  logic signed [SAMPLE_W-1:0] out_right_r;

  logic             in_acc;
  logic             out_free;
  logic [GAIN_W-1:0] tl_eff;
  logic [GAIN_W-1:0] tr_eff;
  logic             releasing;

  ring_ctrl_t ring_ctrl;
  sm_ctrl_t   sm_ctrl;
  wg_ctrl_t   wg_ctrl;

  logic [SAMPLE_W-1:0]        rd_sample;
  logic [SG_W-1:0]            gain_left;
  logic [SG_W-1:0]            gain_right;
  logic signed [SAMPLE_W-1:0] res_left;
  logic signed [SAMPLE_W-1:0] res_right;

  assign in_stall  = (state_r != ST_IDLE);
  assign in_acc    = in_valid && !in_stall;
  assign out_free  = !out_valid_r || !out_stall;
  assign cfg_ready = 1'b1;

  // Effective targets: clip to unity, zero when the voice is off
  assign tl_eff = !in_voice_enabled ? '0 :
                  (in_target_gain_left > UNITY_Q15) ? UNITY_Q15 : in_target_gain_left;
  assign tr_eff = !in_voice_enabled ? '0 :
                  (in_target_gain_right > UNITY_Q15) ? UNITY_Q15 : in_target_gain_right;

  assign releasing = running_r && ((gain_left > GAIN_FLOOR) || (gain_right > GAIN_FLOOR));

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      offset_r  <= '0;
      attack_r  <= ATTACK_RST;
      release_r <= RELEASE_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_DELAY_OFFSET: offset_r  <= cfg_data[OFF_W-1:0];
        CFG_ATTACK_COEF:  attack_r  <= cfg_data[COEF_W-1:0];
        CFG_RELEASE_COEF: release_r <= cfg_data[COEF_W-1:0];
        default: ;
      endcase
    end
  end

  // Capture the input beat
  always_ff @(posedge clk) begin
    if (in_acc) begin
      sample_r <= in_voice_sample;
      tl_r     <= tl_eff;
      tr_r     <= tr_eff;
      en_r     <= in_voice_enabled;
      bs_r     <= in_block_start;
    end
  end

  // Sequencer and block decision
  always_comb begin
    state_nxt   = state_r;
    cnt_nxt     = cnt_r;
    mode_nxt    = mode_r;
    running_nxt = running_r;
    ring_ctrl   = '0;
    sm_ctrl     = '0;
    wg_ctrl     = '0;
    unique case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          state_nxt = ST_DEC;
        end
      end
      ST_DEC: begin
        if (bs_r) begin
          if (!en_r && !releasing) begin
            running_nxt = 1'b0;
            mode_nxt    = MODE_IDLE;
            sm_ctrl.clr = 1'b1;
          end else begin
            running_nxt       = 1'b1;
            ring_ctrl.restart = !running_r;
            if ((tl_r != '0) || (tr_r != '0) || releasing) begin
              mode_nxt    = MODE_AUDIBLE;
              sm_ctrl.clr = !running_r;
            end else begin
              mode_nxt    = MODE_SILENT;
              sm_ctrl.clr = 1'b1;
            end
          end
        end
        ring_ctrl.wr = (mode_nxt != MODE_IDLE);
        state_nxt    = (mode_nxt == MODE_AUDIBLE) ? ST_RD : ST_FIN;
      end
      ST_RD: begin
        ring_ctrl.rd = 1'b1;
        sm_ctrl.load = 1'b1;
        cnt_nxt      = '0;
        state_nxt    = ST_SM;
      end
      ST_SM: begin
        sm_ctrl.mac = 1'b1;
        if (cnt_r == CNT_W'(SM_DIGITS - 1)) begin
          cnt_nxt   = '0;
          state_nxt = ST_UPD;
        end else begin
          cnt_nxt = cnt_r + CNT_W'(1);
        end
      end
      ST_UPD: begin
        sm_ctrl.upd  = 1'b1;
        wg_ctrl.load = 1'b1;
        cnt_nxt      = '0;
        state_nxt    = ST_WG;
      end
      ST_WG: begin
        wg_ctrl.mac = 1'b1;
        if (cnt_r == CNT_W'(WG_DIGITS - 1)) begin
          cnt_nxt   = '0;
          state_nxt = ST_FIN;
        end else begin
          cnt_nxt = cnt_r + CNT_W'(1);
        end
      end
      ST_FIN: begin
        if (out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_IDLE;
      cnt_r     <= '0;
      mode_r    <= MODE_IDLE;
      running_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      cnt_r     <= cnt_nxt;
      mode_r    <= mode_nxt;
      running_r <= running_nxt;
    end
  end

  // Output register: load on finish, drop once taken
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if ((state_r == ST_FIN) && out_free) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if ((state_r == ST_FIN) && out_free) begin
      out_left_r  <= (mode_r == MODE_AUDIBLE) ? res_left : '0;
      out_right_r <= (mode_r == MODE_AUDIBLE) ? res_right : '0;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_left_out  = out_left_r;
  assign out_right_out = out_right_r;

  vdgs_ring u_ring (
    .clk       (clk),
    .rst_n     (rst_n),
    .ctrl      (ring_ctrl),
    .wr_sample (sample_r),
    .offset    (offset_r),
    .rd_sample (rd_sample)
  );

  vdgs_smooth u_smooth_left (
    .clk       (clk),
    .rst_n     (rst_n),
    .ctrl      (sm_ctrl),
    .target    (tl_r),
    .attack    (attack_r),
    .release_c (release_r),
    .gain      (gain_left)
  );

  vdgs_smooth u_smooth_right (
    .clk       (clk),
    .rst_n     (rst_n),
    .ctrl      (sm_ctrl),
    .target    (tr_r),
    .attack    (attack_r),
    .release_c (release_r),
    .gain      (gain_right)
  );

  vdgs_weigh u_weigh_left (
    .clk     (clk),
    .ctrl    (wg_ctrl),
    .dig_idx (cnt_r),
    .sample  ($signed(rd_sample)),
    .gain    (gain_left),
    .result  (res_left)
  );

  vdgs_weigh u_weigh_right (
    .clk     (clk),
    .ctrl    (wg_ctrl),
    .dig_idx (cnt_r),
    .sample  ($signed(rd_sample)),
    .gain    (gain_right),
    .result  (res_right)
  );

endmodule

// ===== rtl/core/vdgs_ring.sv =====
module vdgs_ring import vdgs_pkg::*; (
  input  logic                clk,
  input  logic                rst_n,
  input  ring_ctrl_t          ctrl,
  input  logic [SAMPLE_W-1:0] wr_sample,
  input  logic [OFF_W-1:0]    offset,
  output logic [SAMPLE_W-1:0] rd_sample
);

  localparam logic [ADDR_W-1:0] WP_LAST = ADDR_W'(DELAY_DEPTH - 1);
  localparam logic [ADDR_W:0]   DEPTH_X = (ADDR_W + 1)'(DELAY_DEPTH);
  localparam logic [FILL_W-1:0] DEPTH_F = FILL_W'(DELAY_DEPTH);

  logic [SAMPLE_W-1:0] mem [DELAY_DEPTH];

  logic [ADDR_W-1:0]   wp_r, wp_nxt;
  logic [FILL_W-1:0]   fill_r, fill_nxt;
  logic [ADDR_W-1:0]   rp_r;
  logic                rp_ok_r;
  logic [SAMPLE_W-1:0] rd_data_r;
  logic                rd_ok_r;

  logic [ADDR_W-1:0]   wp_use;
  logic [FILL_W-1:0]   fill_use;
  logic [ADDR_W-1:0]   off_eff;
  logic [ADDR_W:0]     rp_wrap;
  logic [ADDR_W-1:0]   rp_calc;
  logic                rp_ok_calc;

  // Restart begins the ring over at slot zero with nothing written
  assign wp_use   = ctrl.restart ? '0 : wp_r;
  assign fill_use = ctrl.restart ? '0 : fill_r;

  // Clamp the offset to the ring depth
  assign off_eff = (32'(offset) > 32'(DELAY_DEPTH - 1)) ? WP_LAST : ADDR_W'(offset);

  // Read address behind the write slot, wrapping around the ring
  assign rp_wrap = {1'b0, wp_use} + DEPTH_X - {1'b0, off_eff};
  assign rp_calc = (wp_use >= off_eff) ? (wp_use - off_eff) : rp_wrap[ADDR_W-1:0];

  always_comb begin
    fill_nxt = fill_r;
    wp_nxt   = wp_r;
    if (ctrl.wr) begin
      fill_nxt = (fill_use < DEPTH_F) ? (fill_use + FILL_W'(1)) : fill_use;
      wp_nxt   = (wp_use == WP_LAST) ? '0 : (wp_use + ADDR_W'(1));
    end
  end

  // Entries past the fill count were not written since restart
  assign rp_ok_calc = (fill_nxt == DEPTH_F) || (FILL_W'(rp_calc) < fill_nxt);

  // Advance pointer and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r   <= '0;
      fill_r <= '0;
    end else begin
      wp_r   <= wp_nxt;
      fill_r <= fill_nxt;
    end
  end

  // Hold the read address for the following cycle
  always_ff @(posedge clk) begin
    if (ctrl.wr) begin
      rp_r    <= rp_calc;
      rp_ok_r <= rp_ok_calc;
    end
  end

  // Write the incoming sample
  always_ff @(posedge clk) begin
    if (ctrl.wr) begin
      mem[wp_use] <= wr_sample;
    end
  end

  // Registered read
  always_ff @(posedge clk) begin
    if (ctrl.rd) begin
      rd_data_r <= mem[rp_r];
      rd_ok_r   <= rp_ok_r;
    end
  end

  assign rd_sample = rd_ok_r ? rd_data_r : '0;

endmodule

// ===== rtl/core/vdgs_smooth.sv =====
module vdgs_smooth import vdgs_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  sm_ctrl_t          ctrl,
  input  logic [GAIN_W-1:0] target,
  input  logic [COEF_W-1:0] attack,
  input  logic [COEF_W-1:0] release_c,
  output logic [SG_W-1:0]   gain
);

  localparam int TSHIFT = SG_W - GAIN_W;
  localparam int PROD_W = SG_W + COEF_W;
  localparam logic [PROD_W-1:0] PROD_ROUND = PROD_W'(1) << (COEF_W - 1);

  logic [SG_W-1:0]   gain_r;
  logic              up_r;
  logic [PROD_W-1:0] d_r;
  logic [COEF_W-1:0] coef_r;
  logic [PROD_W-1:0] acc_r;

  logic [SG_W-1:0]   t_full;
  logic              up;
  logic [SG_W-1:0]   diff;
  logic [PROD_W-1:0] mac_term;
  logic [PROD_W-1:0] rnd;
  logic [SG_W-1:0]   step;

  // Distance to the target, Q1.31
  assign t_full = {target, {TSHIFT{1'b0}}};
  assign up     = t_full > gain_r;
  assign diff   = up ? (t_full - gain_r) : (gain_r - t_full);

  // One coefficient digit per cycle, least significant first
  assign mac_term = d_r * PROD_W'(coef_r[DIG_W-1:0]);

  // Round the product back to Q1.31
  assign rnd  = acc_r + PROD_ROUND;
  assign step = rnd[COEF_W +: SG_W];

  // Gain register: clear, or move toward the target
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gain_r <= '0;
    end else if (ctrl.clr) begin
      gain_r <= '0;
    end else if (ctrl.upd) begin
      gain_r <= up_r ? (gain_r + step) : (gain_r - step);
    end
  end

  // Multiply-accumulate datapath
  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      up_r   <= up;
      d_r    <= PROD_W'(diff);
      coef_r <= up ? attack : release_c;
      acc_r  <= '0;
    end else if (ctrl.mac) begin
      acc_r  <= acc_r + mac_term;
      d_r    <= d_r << DIG_W;
      coef_r <= coef_r >> DIG_W;
    end
  end

  assign gain = gain_r;

endmodule

// ===== rtl/core/vdgs_weigh.sv =====
module vdgs_weigh import vdgs_pkg::*; (
  input  logic                       clk,
  input  wg_ctrl_t                   ctrl,
  input  logic [CNT_W-1:0]           dig_idx,
  input  logic signed [SAMPLE_W-1:0] sample,
  input  logic [SG_W-1:0]            gain,
  output logic signed [SAMPLE_W-1:0] result
);

  localparam int ACC_W = SAMPLE_W + SG_W + 1;
  localparam int SHR_W = ACC_W - (SG_W - 1);
  localparam logic signed [ACC_W-1:0] WG_ROUND = ACC_W'(1) << (SG_W - 2);
  localparam logic signed [SHR_W-1:0] SAT_HI =
    SHR_W'((64'sd1 <<< (SAMPLE_W - 1)) - 64'sd1);
  localparam logic signed [SHR_W-1:0] SAT_LO = SHR_W'(-(64'sd1 <<< (SAMPLE_W - 1)));

  logic signed [ACC_W-1:0] s_r;
  logic signed [ACC_W-1:0] acc_r;

  logic [DIG_W-1:0]        g_dig;
  logic signed [ACC_W-1:0] term;
  logic signed [SHR_W-1:0] shr;

  // Gain digit for this step, least significant first
  assign g_dig = gain[dig_idx*DIG_W +: DIG_W];
  assign term  = s_r * ACC_W'($signed({1'b0, g_dig}));

  // Accumulate sample times gain with the half-up rounding offset preloaded
  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      s_r   <= ACC_W'(sample);
      acc_r <= WG_ROUND;
    end else if (ctrl.mac) begin
      acc_r <= acc_r + term;
      s_r   <= s_r <<< DIG_W;
    end
  end

  // Drop the Q1.31 fraction and saturate
  assign shr = $signed(acc_r[ACC_W-1:SG_W-1]);

  always_comb begin
    if (shr > SAT_HI) begin
      result = SAMPLE_W'(SAT_HI);
    end else if (shr < SAT_LO) begin
      result = SAMPLE_W'(SAT_LO);
    end else begin
      result = shr[SAMPLE_W-1:0];
    end
  end

endmodule
